// ===== rtl/plc_pkg.sv =====
`timescale 1ns / 1ps
package plc_pkg;

   localparam int WINDOW_SAMPLES_DEF = 5;
   localparam int DATA_W             = 8;
   localparam int PHASE_W            = 3;
   localparam int CSR_IDX_W          = 3;

   typedef enum logic [PHASE_W-1:0] {
      PH_SCAN  = 3'd0,
      PH_OPEN  = 3'd1,
      PH_HOLD  = 3'd2,
      PH_CLOSE = 3'd3,
      PH_STAB  = 3'd4
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VALID_MIN    = 3'd0,
      CSR_VALID_MAX    = 3'd1,
      CSR_DETECT       = 3'd2,
      CSR_OPEN_SETTLE  = 3'd3,
      CSR_HOLD         = 3'd4,
      CSR_CLOSE_SETTLE = 3'd5,
      CSR_STABILIZE    = 3'd6,
      CSR_OPEN_ANGLE   = 3'd7
   } csr_index_type;

   localparam logic [DATA_W-1:0] VALID_MIN_RST    = 8'd2;
   localparam logic [DATA_W-1:0] VALID_MAX_RST    = 8'd200;
   localparam logic [DATA_W-1:0] DETECT_RST       = 8'd10;
   localparam logic [DATA_W-1:0] OPEN_SETTLE_RST  = 8'd1;
   localparam logic [DATA_W-1:0] HOLD_RST         = 8'd10;
   localparam logic [DATA_W-1:0] CLOSE_SETTLE_RST = 8'd1;
   localparam logic [DATA_W-1:0] STABILIZE_RST    = 8'd2;
   localparam logic [DATA_W-1:0] OPEN_ANGLE_RST   = 8'd90;
   localparam logic [DATA_W-1:0] CLOSED_ANGLE     = 8'd0;

   typedef enum logic [1:0] {
      CS_IDLE  = 2'd0,
      CS_EXEC  = 2'd1,
      CS_DIV   = 2'd2,
      CS_WRITE = 2'd3
   } ctl_state_type;

   typedef struct packed {
      logic take;
      logic exec;
      logic div_step;
      logic write;
   } ctl_cmd_type;

   typedef struct packed {
      logic item_valid;
      logic div_needed;
      logic div_last;
      logic out_free;
   } ctl_status_type;

endpackage

// ===== rtl/plc_req_if.sv =====
`timescale 1ns / 1ps
interface plc_req_if;
   logic                        valid;
   logic                        ready;
   logic                        opcode;
   logic [plc_pkg::DATA_W-1:0]  distance_cm;

   modport source (output valid, output opcode, output distance_cm, input ready);
   modport sink   (input valid, input opcode, input distance_cm, output ready);
endinterface

// ===== rtl/plc_rsp_if.sv =====
`timescale 1ns / 1ps
interface plc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [plc_pkg::PHASE_W-1:0]  phase;
   logic [plc_pkg::DATA_W-1:0]   servo_angle;
   logic                         drive_enable;
   logic [plc_pkg::DATA_W-1:0]   countdown;
   logic                         average_valid;
   logic [plc_pkg::DATA_W-1:0]   average_cm;
   logic                         detected;

   modport source (output valid, output phase, output servo_angle, output drive_enable,
                   output countdown, output average_valid, output average_cm,
                   output detected, input ready);
   modport sink   (input valid, input phase, input servo_angle, input drive_enable,
                   input countdown, input average_valid, input average_cm,
                   input detected, output ready);
endinterface

// ===== rtl/proximity_lid_controller.sv =====
`timescale 1ns / 1ps
// Sequence: the request is taken in the idle state, then executed; when the sample closes
//   a window the divider steps (two quotient bits each, for an 11-bit sum) before the
//   response is registered in the write state. One transaction is in flight at a time;
//   the radix-4 divider forms the window average, and an output stall holds the write state.
// Reset: synchronous, active high; configuration and control registers return to
//   defaults, scanning with an empty window, any pending response dropped.
module proximity_lid_controller #(
   parameter int WINDOW_SAMPLES = plc_pkg::WINDOW_SAMPLES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   plc_req_if.sink                       req_chan,
   plc_rsp_if.source                     rsp_chan,
   input  logic                          csr_write_en,
   input  logic [plc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [plc_pkg::DATA_W-1:0]    csr_wdata
);

   plc_pkg::ctl_cmd_type    cmd;
   plc_pkg::ctl_status_type status;

   plc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   plc_datapath #(
      .WINDOW_SAMPLES (WINDOW_SAMPLES)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req          (req_chan),
      .rsp          (rsp_chan)
   );

   // one transaction in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request taken while a transaction is in flight");

   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.detected |->
         rsp_chan.average_valid && rsp_chan.phase == plc_pkg::PH_OPEN && rsp_chan.drive_enable)
      else $error("detection without a completed window or opening phase");

   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.average_valid |->
         rsp_chan.average_cm == '0 && !rsp_chan.detected)
      else $error("average reported without a completed window");

   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.phase == plc_pkg::PH_SCAN |->
         rsp_chan.countdown == '0 && rsp_chan.servo_angle == plc_pkg::CLOSED_ANGLE)
      else $error("scanning with a running timer or open lid");

endmodule

// ===== rtl/plc_div.sv =====
`timescale 1ns / 1ps
module plc_div #(
   parameter int SUM_W = 11,
   parameter int CNT_W = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  logic             step,
   input  logic [SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic [SUM_W-1:0] quotient,
   output logic             last
);

   localparam int STEPS    = 2;
   localparam int DIV_W    = SUM_W + (SUM_W % STEPS);
   localparam int DIV_ITER = DIV_W / STEPS;
   localparam int ITER_W   = $clog2(DIV_ITER + 1);
   localparam int REM_W    = CNT_W + 1;

   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;
   logic [ITER_W-1:0] iter_ff, iter_in;

   logic [REM_W-1:0]  r_w [0:STEPS];
   logic [DIV_W-1:0]  q_w [0:STEPS];
   logic [REM_W:0]    t_w [0:STEPS-1];
   logic [REM_W:0]    dvs_ext;
   logic              ge_w [0:STEPS-1];

   // restoring division, two quotient bits per cycle
   always_comb begin
      dvs_ext = {{(REM_W+1-CNT_W){1'b0}}, dvs_ff};
      r_w[0]  = rem_ff;
      q_w[0]  = quo_ff;
      for (int k = 0; k < STEPS; k++) begin
         t_w[k]    = {r_w[k], q_w[k][DIV_W-1]};
         ge_w[k]   = (t_w[k] >= dvs_ext);
         r_w[k+1]  = ge_w[k] ? REM_W'(t_w[k] - dvs_ext) : t_w[k][REM_W-1:0];
         q_w[k+1]  = {q_w[k][DIV_W-2:0], ge_w[k]};
      end
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      iter_in = iter_ff;
      if (load) begin
         rem_in  = '0;
         quo_in  = DIV_W'(dividend);
         dvs_in  = divisor;
         iter_in = '0;
      end else if (step) begin
         rem_in  = r_w[STEPS];
         quo_in  = q_w[STEPS];
         iter_in = iter_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_ff <= '0;
      end else begin
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff[SUM_W-1:0];
   assign last     = (iter_ff == ITER_W'(DIV_ITER - 1));

endmodule

// ===== rtl/plc_datapath.sv =====
`timescale 1ns / 1ps
module plc_datapath #(
   parameter int WINDOW_SAMPLES = plc_pkg::WINDOW_SAMPLES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  plc_pkg::ctl_cmd_type          cmd,
   output plc_pkg::ctl_status_type       status,
   input  logic                          csr_write_en,
   input  logic [plc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [plc_pkg::DATA_W-1:0]    csr_wdata,
   plc_req_if.sink                       req,
   plc_rsp_if.source                     rsp
);

   localparam int DW    = plc_pkg::DATA_W;
   localparam int CNT_W = $clog2(WINDOW_SAMPLES + 1);
   localparam int SUM_W = $clog2(WINDOW_SAMPLES * 255 + 1);

   // configuration
   logic [DW-1:0] vmin_ff, vmin_in, vmax_ff, vmax_in, detect_ff, detect_in;
   logic [DW-1:0] oset_ff, oset_in, hold_ff, hold_in, cset_ff, cset_in;
   logic [DW-1:0] stab_ff, stab_in, angle_ff, angle_in;

   // item and window state
   logic                 op_ff, op_in;
   logic [DW-1:0]        dist_ff, dist_in;
   plc_pkg::phase_type   phase_ff, phase_in;
   logic [CNT_W-1:0]     idx_ff, idx_in, cnt_ff, cnt_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [DW-1:0]        timer_ff, timer_in;
   logic                 win_ff, win_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   plc_pkg::phase_type   o_phase_ff, o_phase_in;
   logic [DW-1:0]        o_angle_ff, o_angle_in, o_count_ff, o_count_in;
   logic [DW-1:0]        o_avg_ff, o_avg_in;
   logic                 o_drive_ff, o_drive_in, o_avgv_ff, o_avgv_in, o_det_ff, o_det_in;

   logic                 capture, keep, sample_scan, tick_act, win, det;
   logic [SUM_W-1:0]     sum_add, quotient;
   logic [CNT_W-1:0]     cnt_add, idx_add;
   logic [DW-1:0]        avg;
   plc_pkg::phase_type   adv_phase, out_phase;
   logic [DW-1:0]        adv_timer, out_timer;
   logic                 div_last;

   assign capture = cmd.take && req.valid;
   assign req.ready = cmd.take;

   assign keep        = (dist_ff >= vmin_ff) && (dist_ff <= vmax_ff);
   assign sample_scan = !op_ff && (phase_ff == plc_pkg::PH_SCAN);
   assign tick_act    = op_ff && (phase_ff != plc_pkg::PH_SCAN);
   assign sum_add     = sum_ff + (keep ? SUM_W'(dist_ff) : '0);
   assign cnt_add     = cnt_ff + CNT_W'(keep);
   assign idx_add     = idx_ff + 1'b1;
   assign win         = sample_scan && (idx_add >= CNT_W'(WINDOW_SAMPLES));

   plc_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .load     (cmd.exec && win),
      .step     (cmd.div_step),
      .dividend ((cnt_add != '0) ? sum_add : '0),
      .divisor  (cnt_add),
      .quotient (quotient),
      .last     (div_last)
   );

   assign avg       = quotient[DW-1:0];
   assign det       = win_ff && (avg != '0) && (avg <= detect_ff);
   assign out_phase = det ? plc_pkg::PH_OPEN : phase_ff;
   assign out_timer = det ? oset_ff : timer_ff;

   assign status.item_valid = req.valid;
   assign status.div_needed = win && (cnt_add != '0);
   assign status.div_last   = div_last;
   assign status.out_free   = !rsp_valid_ff || rsp.ready;

   always_comb begin
      case (phase_ff)
         plc_pkg::PH_OPEN: begin
            adv_phase = plc_pkg::PH_HOLD;
            adv_timer = hold_ff;
         end
         plc_pkg::PH_HOLD: begin
            adv_phase = plc_pkg::PH_CLOSE;
            adv_timer = cset_ff;
         end
         plc_pkg::PH_CLOSE: begin
            adv_phase = plc_pkg::PH_STAB;
            adv_timer = stab_ff;
         end
         default: begin
            adv_phase = plc_pkg::PH_SCAN;
            adv_timer = '0;
         end
      endcase
   end

   always_comb begin
      vmin_in   = vmin_ff;
      vmax_in   = vmax_ff;
      detect_in = detect_ff;
      oset_in   = oset_ff;
      hold_in   = hold_ff;
      cset_in   = cset_ff;
      stab_in   = stab_ff;
      angle_in  = angle_ff;
      if (csr_write_en) begin
         case (plc_pkg::csr_index_type'(csr_index))
            plc_pkg::CSR_VALID_MIN:    vmin_in   = csr_wdata;
            plc_pkg::CSR_VALID_MAX:    vmax_in   = csr_wdata;
            plc_pkg::CSR_DETECT:       detect_in = csr_wdata;
            plc_pkg::CSR_OPEN_SETTLE:  oset_in   = csr_wdata;
            plc_pkg::CSR_HOLD:         hold_in   = csr_wdata;
            plc_pkg::CSR_CLOSE_SETTLE: cset_in   = csr_wdata;
            plc_pkg::CSR_STABILIZE:    stab_in   = csr_wdata;
            plc_pkg::CSR_OPEN_ANGLE:   angle_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      op_in    = capture ? req.opcode : op_ff;
      dist_in  = capture ? req.distance_cm : dist_ff;
      phase_in = phase_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      timer_in = timer_ff;
      win_in   = win_ff;
      if (cmd.exec) begin
         win_in = win;
         if (sample_scan) begin
            if (win) begin
               idx_in = '0;
               cnt_in = '0;
               sum_in = '0;
            end else begin
               idx_in = idx_add;
               cnt_in = cnt_add;
               sum_in = sum_add;
            end
         end
         if (tick_act) begin
            if (timer_ff > 8'd1) begin
               timer_in = timer_ff - 1'b1;
            end else begin
               phase_in = adv_phase;
               timer_in = adv_timer;
            end
         end
      end
      if (cmd.write) begin
         phase_in = out_phase;
         timer_in = out_timer;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      o_phase_in   = o_phase_ff;
      o_angle_in   = o_angle_ff;
      o_drive_in   = o_drive_ff;
      o_count_in   = o_count_ff;
      o_avgv_in    = o_avgv_ff;
      o_avg_in     = o_avg_ff;
      o_det_in     = o_det_ff;
      if (cmd.write) begin
         rsp_valid_in = 1'b1;
         o_phase_in   = out_phase;
         o_angle_in   = (out_phase == plc_pkg::PH_OPEN || out_phase == plc_pkg::PH_HOLD)
                        ? angle_ff : plc_pkg::CLOSED_ANGLE;
         o_drive_in   = (out_phase == plc_pkg::PH_SCAN || out_phase == plc_pkg::PH_OPEN
                         || out_phase == plc_pkg::PH_CLOSE);
         o_count_in   = out_timer;
         o_avgv_in    = win_ff;
         o_avg_in     = win_ff ? avg : '0;
         o_det_in     = det;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vmin_ff      <= plc_pkg::VALID_MIN_RST;
         vmax_ff      <= plc_pkg::VALID_MAX_RST;
         detect_ff    <= plc_pkg::DETECT_RST;
         oset_ff      <= plc_pkg::OPEN_SETTLE_RST;
         hold_ff      <= plc_pkg::HOLD_RST;
         cset_ff      <= plc_pkg::CLOSE_SETTLE_RST;
         stab_ff      <= plc_pkg::STABILIZE_RST;
         angle_ff     <= plc_pkg::OPEN_ANGLE_RST;
         phase_ff     <= plc_pkg::PH_SCAN;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         timer_ff     <= '0;
         win_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vmin_ff      <= vmin_in;
         vmax_ff      <= vmax_in;
         detect_ff    <= detect_in;
         oset_ff      <= oset_in;
         hold_ff      <= hold_in;
         cset_ff      <= cset_in;
         stab_ff      <= stab_in;
         angle_ff     <= angle_in;
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         timer_ff     <= timer_in;
         win_ff       <= win_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      dist_ff    <= dist_in;
      o_phase_ff <= o_phase_in;
      o_angle_ff <= o_angle_in;
      o_drive_ff <= o_drive_in;
      o_count_ff <= o_count_in;
      o_avgv_ff  <= o_avgv_in;
      o_avg_ff   <= o_avg_in;
      o_det_ff   <= o_det_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.phase         = o_phase_ff;
   assign rsp.servo_angle   = o_angle_ff;
   assign rsp.drive_enable  = o_drive_ff;
   assign rsp.countdown     = o_count_ff;
   assign rsp.average_valid = o_avgv_ff;
   assign rsp.average_cm    = o_avg_ff;
   assign rsp.detected      = o_det_ff;

endmodule

// ===== rtl/plc_ctrl.sv =====
`timescale 1ns / 1ps
module plc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  plc_pkg::ctl_status_type status,
   output plc_pkg::ctl_cmd_type    cmd
);

   plc_pkg::ctl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         plc_pkg::CS_IDLE:  if (status.item_valid) state_in = plc_pkg::CS_EXEC;
         plc_pkg::CS_EXEC:  state_in = status.div_needed ? plc_pkg::CS_DIV : plc_pkg::CS_WRITE;
         plc_pkg::CS_DIV:   if (status.div_last) state_in = plc_pkg::CS_WRITE;
         plc_pkg::CS_WRITE: if (status.out_free) state_in = plc_pkg::CS_IDLE;
         default:           state_in = plc_pkg::CS_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         plc_pkg::CS_IDLE:  cmd.take     = 1'b1;
         plc_pkg::CS_EXEC:  cmd.exec     = 1'b1;
         plc_pkg::CS_DIV:   cmd.div_step = 1'b1;
         plc_pkg::CS_WRITE: cmd.write    = status.out_free;
         default:           cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plc_pkg::CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== tb/tb_proximity_lid_controller.sv =====
`timescale 1ns / 1ps
module tb_proximity_lid_controller;
   import plc_pkg::*;

   localparam int          WINDOW_LEN  = WINDOW_SAMPLES_DEF;
   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int          DRAIN_WAIT  = 12;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [DATA_W-1:0]  servo_angle;
      logic               drive_enable;
      logic [DATA_W-1:0]  countdown;
      logic               average_valid;
      logic [DATA_W-1:0]  average_cm;
      logic               detected;
   } lid_status_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_VALID_MIN;
   logic [DATA_W-1:0]    csr_wdata = '0;

   plc_req_if req_chan ();
   plc_rsp_if rsp_chan ();

   proximity_lid_controller #(.WINDOW_SAMPLES(WINDOW_LEN)) dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #2 clock = ~clock;

   // lid predictor state and its copy of the registers
   logic [DATA_W-1:0] lid_cfg [8];
   phase_type         lid_phase;
   logic [DATA_W-1:0] tick_timer;
   int unsigned       win_count;
   int unsigned       win_sum;
   int unsigned       win_kept;

   lid_status_type pending_status [$];
   int unsigned fail_count    = 0;
   int unsigned cycle_count   = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_idle_pct  = 0;
   int unsigned hold_off_len  = 0;

   initial begin
      req_chan.valid       = 1'b0;
      req_chan.opcode      = 1'b0;
      req_chan.distance_cm = '0;
      lid_cfg[CSR_VALID_MIN]    = VALID_MIN_RST;
      lid_cfg[CSR_VALID_MAX]    = VALID_MAX_RST;
      lid_cfg[CSR_DETECT]       = DETECT_RST;
      lid_cfg[CSR_OPEN_SETTLE]  = OPEN_SETTLE_RST;
      lid_cfg[CSR_HOLD]         = HOLD_RST;
      lid_cfg[CSR_CLOSE_SETTLE] = CLOSE_SETTLE_RST;
      lid_cfg[CSR_STABILIZE]    = STABILIZE_RST;
      lid_cfg[CSR_OPEN_ANGLE]   = OPEN_ANGLE_RST;
      lid_phase  = PH_SCAN;
      tick_timer = '0;
      win_count  = 0;
      win_sum    = 0;
      win_kept   = 0;
   end

   function automatic lid_status_type next_lid_status(logic op, logic [DATA_W-1:0] dist_cm);
      lid_status_type    r;
      logic [DATA_W-1:0] avg;
      r   = '0;
      avg = '0;
      if (op == 1'b0) begin
         if (lid_phase == PH_SCAN) begin
            if (dist_cm >= lid_cfg[CSR_VALID_MIN] && dist_cm <= lid_cfg[CSR_VALID_MAX]) begin
               win_sum  += dist_cm;
               win_kept += 1;
            end
            win_count += 1;
            if (win_count >= WINDOW_LEN) begin
               avg = (win_kept != 0) ? DATA_W'(win_sum / win_kept) : '0;
               r.average_valid = 1'b1;
               r.average_cm    = avg;
               win_count = 0;
               win_sum   = 0;
               win_kept  = 0;
               if (avg != 0 && avg <= lid_cfg[CSR_DETECT]) begin
                  r.detected = 1'b1;
                  lid_phase  = PH_OPEN;
                  tick_timer = lid_cfg[CSR_OPEN_SETTLE];
               end
            end
         end
      end else if (lid_phase != PH_SCAN) begin
         // counts of 0 and 1 both last a single tick
         if (tick_timer > 1) begin
            tick_timer = tick_timer - 1'b1;
         end else begin
            case (lid_phase)
               PH_OPEN: begin
                  lid_phase  = PH_HOLD;
                  tick_timer = lid_cfg[CSR_HOLD];
               end
               PH_HOLD: begin
                  lid_phase  = PH_CLOSE;
                  tick_timer = lid_cfg[CSR_CLOSE_SETTLE];
               end
               PH_CLOSE: begin
                  lid_phase  = PH_STAB;
                  tick_timer = lid_cfg[CSR_STABILIZE];
               end
               default: begin
                  lid_phase  = PH_SCAN;
                  tick_timer = '0;
               end
            endcase
         end
      end
      r.phase        = lid_phase;
      r.servo_angle  = (lid_phase == PH_OPEN || lid_phase == PH_HOLD) ?
                       lid_cfg[CSR_OPEN_ANGLE] : CLOSED_ANGLE;
      r.drive_enable = (lid_phase == PH_SCAN || lid_phase == PH_OPEN ||
                        lid_phase == PH_CLOSE);
      r.countdown    = tick_timer;
      return r;
   endfunction

   function automatic void compare_field(string name, logic [DATA_W-1:0] want,
                                         logic [DATA_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // response checker
   always @(posedge clock) begin : check_proc
      lid_status_type want;
      if (reset == 1'b0 && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_status.size() == 0) begin
            $error("response transaction with no expected status pending");
            fail_count++;
         end else begin
            want = pending_status.pop_front();
            compare_field("phase", DATA_W'(want.phase), DATA_W'(rsp_chan.phase));
            compare_field("servo_angle", want.servo_angle, rsp_chan.servo_angle);
            compare_field("drive_enable", DATA_W'(want.drive_enable),
                          DATA_W'(rsp_chan.drive_enable));
            compare_field("countdown", want.countdown, rsp_chan.countdown);
            compare_field("average_valid", DATA_W'(want.average_valid),
                          DATA_W'(rsp_chan.average_valid));
            compare_field("average_cm", want.average_cm, rsp_chan.average_cm);
            compare_field("detected", DATA_W'(want.detected), DATA_W'(rsp_chan.detected));
         end
      end
   end

   // response ready, with an optional long hold-off
   initial begin : rsp_ready_proc
      int unsigned k;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_len != 0) begin
            rsp_chan.ready <= 1'b0;
            for (k = 0; k < hold_off_len; k++) @(posedge clock);
            hold_off_len = 0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_lid_item(input logic op, input logic [DATA_W-1:0] dist_cm);
      lid_status_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.opcode      <= op;
      req_chan.distance_cm <= dist_cm;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      want = next_lid_status(op, dist_cm);
      pending_status.push_back(want);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_lid_config(input logic [DATA_W-1:0] vmin, vmax, det, open_s, hold,
                                   close_s, stab, angle);
      logic [DATA_W-1:0] vals [8];
      vals[CSR_VALID_MIN]    = vmin;
      vals[CSR_VALID_MAX]    = vmax;
      vals[CSR_DETECT]       = det;
      vals[CSR_OPEN_SETTLE]  = open_s;
      vals[CSR_HOLD]         = hold;
      vals[CSR_CLOSE_SETTLE] = close_s;
      vals[CSR_STABILIZE]    = stab;
      vals[CSR_OPEN_ANGLE]   = angle;
      for (int i = 0; i < 8; i++) begin
         csr_write_en <= 1'b1;
         csr_index    <= csr_index_type'(i);
         csr_wdata    <= vals[i];
         lid_cfg[i]    = vals[i];
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
   endtask

   function automatic logic [DATA_W-1:0] pick_ticks();
      if ($urandom_range(7) == 0) return DATA_W'($urandom_range(16, 5));
      return DATA_W'($urandom_range(4));
   endfunction

   task automatic write_random_config();
      logic [DATA_W-1:0] vmin, vmax, det, angle;
      vmin  = ($urandom_range(9) == 0) ? DATA_W'($urandom_range(255)) :
                                         DATA_W'($urandom_range(8));
      vmax  = ($urandom_range(9) == 0) ? DATA_W'($urandom_range(255)) :
                                         DATA_W'($urandom_range(255, 120));
      det   = ($urandom_range(9) == 0) ? 8'd255 : DATA_W'($urandom_range(80));
      angle = ($urandom_range(9) == 0) ? DATA_W'($urandom_range(255)) :
                                         DATA_W'($urandom_range(180));
      write_lid_config(vmin, vmax, det, pick_ticks(), pick_ticks(), pick_ticks(),
                       pick_ticks(), angle);
   endtask

   // near windows aim their samples at the detect range so the lid sequence runs often
   function automatic logic [DATA_W-1:0] pick_distance(bit near);
      int unsigned lo, hi, r;
      r  = $urandom_range(99);
      lo = (lid_cfg[CSR_VALID_MIN] == 0) ? 1 : lid_cfg[CSR_VALID_MIN];
      hi = (lid_cfg[CSR_DETECT] < lid_cfg[CSR_VALID_MAX]) ? lid_cfg[CSR_DETECT] :
                                                            lid_cfg[CSR_VALID_MAX];
      if (r < 6) return 8'd0;
      if (r < 10) return 8'd255;
      if (near && r < 85 && lo <= hi) return DATA_W'($urandom_range(hi, lo));
      return DATA_W'($urandom_range(255));
   endfunction

   // count only transactions the block acts on
   task automatic run_random_items(input int unsigned count);
      int unsigned done;
      logic        op;
      bit          useful;
      bit          near_window;
      done        = 0;
      near_window = 1'b1;
      while (done < count) begin
         if (lid_phase == PH_SCAN) op = ($urandom_range(99) < 8);
         else                      op = ($urandom_range(99) < 85);
         useful = (op == 1'b0) ? (lid_phase == PH_SCAN) : (lid_phase != PH_SCAN);
         if (op == 1'b0 && lid_phase == PH_SCAN && win_count == 0)
            near_window = ($urandom_range(99) < 60);
         send_lid_item(op, pick_distance(near_window));
         if (useful) done++;
      end
   endtask

   task automatic test_reset_defaults();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      send_lid_item(1'b1, 8'd77);           // tick while scanning
      send_lid_item(1'b0, 8'd0);            // no echo
      send_lid_item(1'b0, 8'd1);
      send_lid_item(1'b0, 8'd2);
      send_lid_item(1'b0, 8'd200);
      send_lid_item(1'b0, 8'd255);
      send_lid_item(1'b0, 8'd201);
      send_lid_item(1'b0, 8'd3);
      send_lid_item(1'b0, 8'd4);
      send_lid_item(1'b0, 8'd5);
      send_lid_item(1'b0, 8'd6);            // mean 4 opens the lid
      send_lid_item(1'b0, 8'd5);            // sample while open
      repeat (14) send_lid_item(1'b1, 8'd0);
      wait_drained();
   endtask

   task automatic test_register_extremes();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      write_lid_config(8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255);
      repeat (WINDOW_LEN) send_lid_item(1'b0, 8'd0);    // zero mean never opens
      repeat (WINDOW_LEN) send_lid_item(1'b0, 8'd255);
      repeat (4) send_lid_item(1'b1, 8'd255);
      wait_drained();
      // empty valid range
      write_lid_config(8'd200, 8'd2, 8'd255, 8'd1, 8'd1, 8'd1, 8'd1, 8'd180);
      send_lid_item(1'b0, 8'd2);
      send_lid_item(1'b0, 8'd200);
      send_lid_item(1'b0, 8'd100);
      send_lid_item(1'b0, 8'd1);
      send_lid_item(1'b0, 8'd170);
      wait_drained();
   endtask

   task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct);
      send_idle_pct = snd_pct;
      rsp_idle_pct  = rcv_pct;
      repeat (3) begin
         write_random_config();
         run_random_items(60);
         wait_drained();
      end
   endtask

   task automatic test_output_backpressure();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      write_lid_config(8'd2, 8'd200, 8'd60, 8'd1, 8'd2, 8'd1, 8'd1, 8'd90);
      @(negedge clock) hold_off_len = 300;
      @(posedge clock);
      run_random_items(24);
      wait_drained();
   endtask

   task automatic test_longest_countdown();
      send_idle_pct = 10;
      rsp_idle_pct  = 10;
      write_lid_config(8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd180);
      repeat (WINDOW_LEN) send_lid_item(1'b0, 8'd128);
      repeat (10) send_lid_item(1'b1, 8'd0);
      send_lid_item(1'b0, 8'd3);
      repeat (10) send_lid_item(1'b1, 8'd0);
      wait_drained();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_register_extremes();
      test_random_traffic(30, 64);
      test_random_traffic(64, 30);
      test_random_traffic(0, 0);
      test_output_backpressure();
      test_longest_countdown();
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
